[design/pwf_pkg.sv]
// ----------------------------------------------------------------------------
// pwf_pkg - palindrome word finder shared definitions
// Widths, word-length limit, character class helpers and memory port struct.
// ----------------------------------------------------------------------------
`default_nettype none

package pwf_pkg;

  localparam int MAX_WORD = 32;
  localparam int LEN_W    = $clog2(MAX_WORD + 1);
  localparam int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] CH_DIGIT_LO = 8'd48;
  localparam logic [CHAR_W-1:0] CH_DIGIT_HI = 8'd57;
  localparam logic [CHAR_W-1:0] CH_UPPER_LO = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_HI = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_HI = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
  localparam logic [LEN_W-1:0]  MIN_REPORT  = LEN_W'(2);
  localparam logic [LEN_W-1:0]  MAX_LEN     = LEN_W'(MAX_WORD);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    char_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  function automatic char_t fold_upper(input char_t ch);
    if (ch >= CH_LOWER_LO && ch <= CH_LOWER_HI) begin
      return ch - CASE_OFFSET;
    end
    return ch;
  endfunction

  function automatic logic is_word_char(input char_t ch);
    char_t up;
    up = fold_upper(ch);
    return (up >= CH_UPPER_LO && up <= CH_UPPER_HI) ||
           (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI);
  endfunction

endpackage

`default_nettype wire

[design/pwf_if.sv]
// ----------------------------------------------------------------------------
// pwf_if - palindrome word finder channels
// Valid/ready channels for sentence bytes in and word characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwf_in_if;
  logic                valid;
  logic                ready;
  pwf_pkg::char_t      text_byte;
  logic                sentence_end;

  modport source (output valid, text_byte, sentence_end, input ready);
  modport sink   (input valid, text_byte, sentence_end, output ready);
endinterface

interface pwf_out_if;
  logic                valid;
  logic                ready;
  pwf_pkg::char_t      word_char;
  logic                word_last;

  modport source (output valid, word_char, word_last, input ready);
  modport sink   (input valid, word_char, word_last, output ready);
endinterface

`default_nettype wire

[design/palindrome_word_finder_top.sv]
// ----------------------------------------------------------------------------
// palindrome_word_finder_top - palindromic word finder
// Collects alphanumeric words from a byte stream and reports palindromes.
// ----------------------------------------------------------------------------
// Channel    Role  Beat payload
// text_in    sink  text_byte[7:0], sentence_end
// word_out   src   word_char[7:0], word_last
//
// A byte that extends a word is taken straight away while the sequencer is idle.
// A closing byte of a reported candidate starts the mirror compare: each pair is
// read from the dual-read word store (registered read data) and checked by one
// compare unit, then each character is read and emitted, held under output stall.
// text_in is not ready from the closing beat until the last character leaves
// or a compare fails.
// Synchronous reset clears the sequencer; the word store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module palindrome_word_finder_top (
  input  wire logic clk,
  input  wire logic rst,
  pwf_in_if.sink    text_in,
  pwf_out_if.source word_out
);

  pwf_pkg::mem_req_t mem_req;
  pwf_pkg::char_t    rd_a;
  pwf_pkg::char_t    rd_b;
  logic              chars_eq;

  pwf_word_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  pwf_cmp_unit u_cmp (
    .a  (rd_a),
    .b  (rd_b),
    .eq (chars_eq)
  );

  pwf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .word_out (word_out),
    .mem_req  (mem_req),
    .rd_a     (rd_a),
    .chars_eq (chars_eq)
  );

endmodule

`default_nettype wire

[design/pwf_word_mem.sv]
// ----------------------------------------------------------------------------
// pwf_word_mem - word character store
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_word_mem (
  input  wire logic              clk,
  input  wire pwf_pkg::mem_req_t req,
  output pwf_pkg::char_t         rd_a,
  output pwf_pkg::char_t         rd_b
);

  pwf_pkg::char_t store [pwf_pkg::MAX_WORD];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
    rd_a <= store[req.raddr_a];
    rd_b <= store[req.raddr_b];
  end

endmodule

`default_nettype wire

[design/pwf_cmp_unit.sv]
// ----------------------------------------------------------------------------
// pwf_cmp_unit - case-insensitive character compare
// Folds both characters to upper case and tests them for equality.
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_cmp_unit (
  input  wire pwf_pkg::char_t a,
  input  wire pwf_pkg::char_t b,
  output logic                eq
);

  assign eq = (pwf_pkg::fold_upper(a) == pwf_pkg::fold_upper(b));

endmodule

`default_nettype wire

[design/pwf_seq.sv]
// ----------------------------------------------------------------------------
// pwf_seq - palindrome word finder sequencer
// Builds words, walks the mirror compare and emits reported characters.
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  pwf_in_if.sink                  text_in,
  pwf_out_if.source               word_out,
  output pwf_pkg::mem_req_t       mem_req,
  input  wire pwf_pkg::char_t     rd_a,
  input  wire logic               chars_eq
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP_RD,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t          state;
  pwf_pkg::len_t   len;
  logic            too_long;
  pwf_pkg::addr_t  lo;
  pwf_pkg::addr_t  hi;
  pwf_pkg::addr_t  k;

  logic            accept;
  logic            word_ch;
  logic            room;
  logic            closing;
  logic            too_long_next;
  pwf_pkg::len_t   len_next;
  logic            drop;
  pwf_pkg::addr_t  lo_next;
  pwf_pkg::addr_t  hi_next;
  logic            last_char;

  assign accept        = text_in.valid && text_in.ready;
  assign word_ch       = pwf_pkg::is_word_char(text_in.text_byte);
  assign room          = (len < pwf_pkg::MAX_LEN);
  assign closing       = !word_ch || text_in.sentence_end;
  assign too_long_next = too_long || (word_ch && !room);
  assign len_next      = (word_ch && room) ? len + pwf_pkg::LEN_W'(1) : len;
  assign drop          = too_long_next || (len_next < pwf_pkg::MIN_REPORT);
  assign lo_next       = lo + pwf_pkg::ADDR_W'(1);
  assign hi_next       = hi - pwf_pkg::ADDR_W'(1);
  assign last_char     = (pwf_pkg::LEN_W'(k) == len - pwf_pkg::LEN_W'(1));

  assign text_in.ready      = (state == S_IDLE);
  assign word_out.valid     = (state == S_EMIT_OUT);
  assign word_out.word_char = rd_a;
  assign word_out.word_last = last_char;

  always_comb begin
    mem_req.we      = accept && word_ch && room;
    mem_req.waddr   = len[pwf_pkg::ADDR_W-1:0];
    mem_req.wdata   = text_in.text_byte;
    mem_req.raddr_a = (state == S_EMIT_RD || state == S_EMIT_OUT) ? k : lo;
    mem_req.raddr_b = hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      too_long <= 1'b0;
      lo       <= '0;
      hi       <= '0;
      k        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!closing) begin
              len      <= len_next;
              too_long <= too_long_next;
            end else if (drop) begin
              len      <= '0;
              too_long <= 1'b0;
            end else begin
              len   <= len_next;
              lo    <= '0;
              hi    <= pwf_pkg::ADDR_W'(len_next - pwf_pkg::LEN_W'(1));
              k     <= '0;
              state <= S_CMP_RD;
            end
          end
        end
        S_CMP_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!chars_eq) begin
            len   <= '0;
            state <= S_IDLE;
          end else if (lo_next < hi_next) begin
            lo    <= lo_next;
            hi    <= hi_next;
            state <= S_CMP_RD;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (word_out.ready) begin
            if (last_char) begin
              len   <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + pwf_pkg::ADDR_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/pwf_checker.sv]
// ----------------------------------------------------------------------------
// pwf_checker - palindrome word finder port checks
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire pwf_pkg::char_t word_char,
  input wire logic           word_last
);

  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(word_char) && $stable(word_last))
    else $error("stalled output beat changed");

  ap_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a word is being reported");

  ap_word_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && word_last |=> !out_valid && in_ready)
    else $error("output continued after the last character");

  ap_word_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !word_last |=> !in_ready)
    else $error("input reopened in the middle of a word");

  ap_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind palindrome_word_finder_top pwf_checker u_pwf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (text_in.ready),
  .out_valid (word_out.valid),
  .out_ready (word_out.ready),
  .word_char (word_out.word_char),
  .word_last (word_out.word_last)
);

`default_nettype wire

[tb/palindrome_word_finder_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palindrome_word_finder_top_test - palindromic word finder testbench
// Feeds sentence bytes on text_in and checks every word character on
// word_out against an in-bench model of word collection, overflow and
// case-folded mirror comparison. Covers directed corner words, a long
// output hold-off with the input kept busy, a full drain, then random
// sentences of mostly well-formed words with some noise bytes.
// ----------------------------------------------------------------------------

module palindrome_word_finder_top_test;

  typedef pwf_pkg::char_t char_t;

  typedef struct {
    char_t b;
    logic  fin;
  } text_beat_t;

  typedef struct {
    char_t ch;
    logic  last;
  } word_beat_t;

  localparam int WORD_CAP    = pwf_pkg::MAX_WORD;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 100;
  localparam int ITEM_TARGET = 350;

  logic clk;
  logic rst;
  logic hold_req;
  int   hold_left;

  pwf_in_if  text_in ();
  pwf_out_if word_out ();

  palindrome_word_finder_top uut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .word_out (word_out)
  );

  text_beat_t sentence_q[$];
  word_beat_t expected_chars[$];

  char_t held_chars[WORD_CAP];
  int    held_len;
  bit    overflowed;

  int err_count;
  int bytes_made;
  int cycle_no;

  int in_pause, in_beats;
  bit in_calm;
  int out_pause, out_beats;
  bit out_calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_alnum(input char_t b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic char_t upcase(input char_t b);
    return (b >= 8'h61 && b <= 8'h7A) ? (b & 8'hDF) : b;
  endfunction

  function automatic int pick_pause(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 14));
  endfunction

  // Close the held word and queue its characters if it mirrors
  task automatic close_word();
    bit mirror;
    word_beat_t wb;
    mirror = !overflowed && held_len >= 2;
    for (int i = 0; i < held_len / 2; i++) begin
      if (upcase(held_chars[i]) != upcase(held_chars[held_len - 1 - i])) mirror = 1'b0;
    end
    if (mirror) begin
      for (int i = 0; i < held_len; i++) begin
        wb.ch = held_chars[i];
        wb.last = (i == held_len - 1);
        expected_chars.insert(expected_chars.size(), wb);
      end
    end
    held_len = 0;
    overflowed = 1'b0;
  endtask

  task automatic take_byte(input char_t b, input logic fin);
    if (is_alnum(b)) begin
      if (held_len < WORD_CAP) begin
        held_chars[held_len] = b;
        held_len++;
      end else begin
        overflowed = 1'b1;
      end
      if (fin) close_word();
    end else begin
      close_word();
    end
  endtask

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  // Input side: hold the beat until taken, then pause before the next
  always @(posedge clk) begin
    text_beat_t nxt;
    if (rst) begin
      text_in.valid <= 1'b0;
      text_in.text_byte <= '0;
      text_in.sentence_end <= 1'b0;
      in_pause = 0;
      in_beats = 0;
      in_calm = 1'b0;
    end else begin
      if (text_in.valid && text_in.ready) begin
        take_byte(text_in.text_byte, text_in.sentence_end);
        in_beats++;
        if (in_beats % 40 == 0) in_calm = ($urandom_range(0, 2) == 0);
        in_pause = pick_pause(in_calm);
      end
      if (!text_in.valid || text_in.ready) begin
        if (in_pause > 0) begin
          in_pause--;
          text_in.valid <= 1'b0;
        end else if (sentence_q.size() > 0) begin
          nxt = sentence_q.pop_front();
          text_in.valid <= 1'b1;
          text_in.text_byte <= nxt.b;
          text_in.sentence_end <= nxt.fin;
        end else begin
          text_in.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each beat against the oldest expected character
  always @(posedge clk) begin
    word_beat_t exp_beat;
    if (rst) begin
      word_out.ready <= 1'b0;
      out_pause = 0;
      out_beats = 0;
      out_calm = 1'b0;
    end else begin
      if (word_out.valid && word_out.ready) begin
        if (expected_chars.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected word beat: char %0h last %0b", $realtime,
                     word_out.word_char, word_out.word_last);
        end else begin
          exp_beat = expected_chars.pop_front();
          if (word_out.word_char !== exp_beat.ch)
            report_mismatch("word_char", exp_beat.ch, word_out.word_char);
          if (word_out.word_last !== exp_beat.last)
            report_mismatch("word_last", exp_beat.last, word_out.word_last);
        end
        out_beats++;
        if (out_beats % 40 == 0) out_calm = ($urandom_range(0, 2) == 0);
        out_pause = pick_pause(out_calm);
      end
      if (out_pause > 0) begin
        out_pause--;
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_req && hold_left == 0) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_byte(input char_t b, input logic fin);
    text_beat_t tb_beat;
    tb_beat.b = b;
    tb_beat.fin = fin;
    sentence_q.insert(sentence_q.size(), tb_beat);
    bytes_made++;
  endtask

  task automatic queue_text(input string s, input bit fin_last);
    for (int i = 0; i < s.len(); i++) queue_byte(char_t'(s[i]), fin_last && i == s.len() - 1);
  endtask

  function automatic char_t pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return char_t'(8'h30 + r);
    if (r < 36) return char_t'(8'h41 + r - 10);
    return char_t'(8'h61 + r - 36);
  endfunction

  function automatic char_t pick_separator();
    char_t b;
    b = char_t'($urandom_range(0, 255));
    while (is_alnum(b)) b = char_t'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 16);
    if (r < 97) return $urandom_range(17, WORD_CAP);
    return $urandom_range(WORD_CAP + 1, WORD_CAP + 8);
  endfunction

  // Build one word, mirrored with random case where asked, then close it
  task automatic queue_word(input int len, input bit mirror);
    char_t w[];
    int r;
    w = new[len];
    for (int i = 0; i < len; i++) w[i] = pick_alnum();
    if (mirror) begin
      for (int i = 0; i < len / 2; i++) begin
        w[len - 1 - i] = w[i];
        if (w[i] >= 8'h41 && $urandom_range(0, 1)) w[len - 1 - i] = w[i] ^ 8'h20;
      end
    end
    r = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) queue_byte(w[i], r < 3 && i == len - 1);
    if (r >= 3) queue_byte(pick_separator(), r == 9);
  endtask

  task automatic wait_drained();
    while (sentence_q.size() != 0 || text_in.valid || expected_chars.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int goal;
    clk = 1'b0;
    rst = 1'b1;
    hold_req = 1'b0;
    text_in.valid = 1'b0;
    text_in.text_byte = '0;
    text_in.sentence_end = 1'b0;
    word_out.ready = 1'b0;
    held_len = 0;
    overflowed = 1'b0;
    err_count = 0;
    bytes_made = 0;
    cycle_no = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    queue_text("Aba ", 1'b0);
    queue_text("x,", 1'b0);
    queue_text("0990", 1'b1);
    queue_text("zZ", 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_text("aB", 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_text("Xy9yx", 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_text("q", 1'b1);
    wait_drained();

    // Hold the output off while palindromes keep arriving
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 12; i++) queue_word($urandom_range(3, 10), 1'b1);
    wait_drained();

    queue_word(WORD_CAP, 1'b1);
    queue_word(WORD_CAP + 1, 1'b1);
    queue_word(WORD_CAP + 8, 1'b0);
    goal = ITEM_TARGET;
    while (bytes_made < goal) begin
      if ($urandom_range(0, 9) == 0)
        queue_byte(char_t'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
      else
        queue_word(pick_len(), $urandom_range(0, 99) < 65);
    end
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && expected_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
